[rtl/gbe_pkg.sv]
// Package for the gap buffer editor: sizes, command and status codes,
// and the item types shared by the front end, back end, top level and checker.
// Depends on nothing.
package gbe_pkg;

  localparam int CAPACITY = 1024;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int PW       = 11;
  localparam int FQ_DEPTH = 2;
  localparam int FQ_CNTW  = $clog2(FQ_DEPTH + 1);

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_MOVE   = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_APPEND = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_MOVE,
    OP_CLEAR,
    OP_APPEND,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]    command;
    logic [PW-1:0] position;
    logic [7:0]    data_char;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [7:0]    read_char;
    logic [PW-1:0] gap_start;
    logic [PW-1:0] text_count;
  } out_item_t;

  typedef struct packed {
    op_t           op;
    logic [PW-1:0] position;
    logic [7:0]    data_char;
  } cmd_t;

endpackage

[rtl/gbe_front.sv]
// Front end of the gap buffer editor: decodes each input beat into an
// operation and holds it in a short queue for the back end.
// Depends on gbe_pkg.
module gbe_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  gbe_pkg::in_item_t  in_item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output gbe_pkg::cmd_t      cmd
);

  gbe_pkg::cmd_t                q_r [gbe_pkg::FQ_DEPTH];
  logic [$clog2(gbe_pkg::FQ_DEPTH)-1:0] wp_r, wp_nxt;
  logic [$clog2(gbe_pkg::FQ_DEPTH)-1:0] rp_r, rp_nxt;
  logic [gbe_pkg::FQ_CNTW-1:0]  cnt_r, cnt_nxt;
  logic                         push_ok;
  logic                         pop_ok;
  gbe_pkg::cmd_t                dec;

  always_comb begin
    dec.position  = in_item.position;
    dec.data_char = in_item.data_char;
    case (in_item.command)
      gbe_pkg::CMD_INSERT: dec.op = gbe_pkg::OP_INSERT;
      gbe_pkg::CMD_MOVE:   dec.op = gbe_pkg::OP_MOVE;
      gbe_pkg::CMD_CLEAR:  dec.op = gbe_pkg::OP_CLEAR;
      gbe_pkg::CMD_APPEND: dec.op = gbe_pkg::OP_APPEND;
      gbe_pkg::CMD_READ:   dec.op = gbe_pkg::OP_READ;
      default:             dec.op = gbe_pkg::OP_NOP;
    endcase
  end

  assign full      = (cnt_r == gbe_pkg::FQ_CNTW'(gbe_pkg::FQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt  = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop_ok ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

[rtl/gbe_back.sv]
// Back end of the gap buffer editor: the character store, the gap and
// length registers, the gap-move sequencer and the result register.
// Depends on gbe_pkg.
module gbe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  gbe_pkg::cmd_t      cmd,
  output logic               empty,
  input  logic               pop,
  output gbe_pkg::out_item_t out_item
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOVE = 4'b0010,
    S_COPY = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  state_t                     st_r, st_nxt;
  logic [gbe_pkg::CW-1:0]     gp_r, gp_nxt;
  logic [gbe_pkg::CW-1:0]     gl_r, gl_nxt;
  logic [gbe_pkg::CW-1:0]     tl_r, tl_nxt;
  logic [gbe_pkg::CW-1:0]     tgt_r, tgt_nxt;
  logic                       wr_after_r, wr_after_nxt;
  logic [7:0]                 ch_r, ch_nxt;
  logic [gbe_pkg::AW-1:0]     waddr_r, waddr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  gbe_pkg::out_item_t         out_data_r, out_data_nxt;

  logic [7:0]                 mem_r [gbe_pkg::CAPACITY];
  logic [7:0]                 rdata_r;
  logic                       mem_we;
  logic [gbe_pkg::AW-1:0]     mem_waddr;
  logic [7:0]                 mem_wdata;
  logic                       mem_re;
  logic [gbe_pkg::AW-1:0]     mem_raddr;

  logic                       res_load;
  logic [1:0]                 res_status;
  logic [7:0]                 res_char;
  logic [gbe_pkg::CW-1:0]     pos;
  logic [gbe_pkg::CW-1:0]     gap_end;
  logic [gbe_pkg::CW-1:0]     gap_last;
  logic [gbe_pkg::CW-1:0]     rd_idx;

  assign pos      = gbe_pkg::CW'(cmd.position);
  assign gap_end  = gp_r + gl_r;
  assign gap_last = gap_end - 1'b1;
  assign rd_idx   = (pos < gp_r) ? pos : pos + gl_r;

  always_comb begin
    st_nxt       = st_r;
    gp_nxt       = gp_r;
    gl_nxt       = gl_r;
    tl_nxt       = tl_r;
    tgt_nxt      = tgt_r;
    wr_after_nxt = wr_after_r;
    ch_nxt       = ch_r;
    waddr_nxt    = waddr_r;
    cmd_ready    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = waddr_r;
    mem_wdata    = rdata_r;
    mem_re       = 1'b0;
    mem_raddr    = gp_r[gbe_pkg::AW-1:0];
    res_load     = 1'b0;
    res_status   = gbe_pkg::ST_OK;
    res_char     = 8'd0;

    case (st_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_ready = 1'b1;
          ch_nxt    = cmd.data_char;
          case (cmd.op)
            gbe_pkg::OP_INSERT: begin
              if (pos > tl_r) begin
                res_load   = 1'b1;
                res_status = gbe_pkg::ST_RANGE;
              end else if (gl_r == '0) begin
                res_load   = 1'b1;
                res_status = gbe_pkg::ST_FULL;
              end else begin
                tgt_nxt      = pos;
                wr_after_nxt = 1'b1;
                st_nxt       = S_MOVE;
              end
            end
            gbe_pkg::OP_MOVE: begin
              if (pos > tl_r) begin
                res_load   = 1'b1;
                res_status = gbe_pkg::ST_RANGE;
              end else begin
                tgt_nxt      = pos;
                wr_after_nxt = 1'b0;
                st_nxt       = S_MOVE;
              end
            end
            gbe_pkg::OP_CLEAR: begin
              gp_nxt   = '0;
              gl_nxt   = gbe_pkg::CW'(gbe_pkg::CAPACITY);
              tl_nxt   = '0;
              res_load = 1'b1;
            end
            gbe_pkg::OP_APPEND: begin
              if (gl_r == '0) begin
                res_load   = 1'b1;
                res_status = gbe_pkg::ST_FULL;
              end else begin
                tgt_nxt      = tl_r;
                wr_after_nxt = 1'b1;
                st_nxt       = S_MOVE;
              end
            end
            gbe_pkg::OP_READ: begin
              if (pos >= tl_r) begin
                res_load   = 1'b1;
                res_status = gbe_pkg::ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = rd_idx[gbe_pkg::AW-1:0];
                st_nxt    = S_READ;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_MOVE: begin
        if (gp_r == tgt_r) begin
          if (wr_after_r) begin
            mem_we    = 1'b1;
            mem_waddr = gp_r[gbe_pkg::AW-1:0];
            mem_wdata = ch_r;
            gp_nxt    = gp_r + 1'b1;
            gl_nxt    = gl_r - 1'b1;
            tl_nxt    = tl_r + 1'b1;
          end
          res_load = 1'b1;
          st_nxt   = S_IDLE;
        end else if (gp_r > tgt_r) begin
          mem_re    = 1'b1;
          mem_raddr = gp_r[gbe_pkg::AW-1:0] - 1'b1;
          waddr_nxt = gap_last[gbe_pkg::AW-1:0];
          gp_nxt    = gp_r - 1'b1;
          st_nxt    = S_COPY;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = gap_end[gbe_pkg::AW-1:0];
          waddr_nxt = gp_r[gbe_pkg::AW-1:0];
          gp_nxt    = gp_r + 1'b1;
          st_nxt    = S_COPY;
        end
      end
      S_COPY: begin
        mem_we = 1'b1;
        st_nxt = S_MOVE;
      end
      S_READ: begin
        res_load = 1'b1;
        res_char = rdata_r;
        st_nxt   = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    out_data_nxt = out_data_r;
    if (res_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.status     = res_status;
      out_data_nxt.read_char  = res_char;
      out_data_nxt.gap_start  = gbe_pkg::PW'(gp_nxt);
      out_data_nxt.text_count = gbe_pkg::PW'(tl_nxt);
    end else if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      gp_r        <= '0;
      gl_r        <= gbe_pkg::CW'(gbe_pkg::CAPACITY);
      tl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      gp_r        <= gp_nxt;
      gl_r        <= gl_nxt;
      tl_r        <= tl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    wr_after_r <= wr_after_nxt;
    ch_r       <= ch_nxt;
    waddr_r    <= waddr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem_r[mem_raddr];
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_data_r;

endmodule

[rtl/gap_buffer_editor_top.sv]
// Top level of the gap buffer editor: joins the decoding front end and
// the executing back end. Depends on gbe_pkg, gbe_front and gbe_back.
//
//   Channel   Ports                  Beat taken when
//   input     push, full, in_item    push high and full low
//   result    empty, pop, out_item   pop high and empty low
//
// Clear, rejected and unused commands end in the back end's idle state, a read
// waits in S_READ for the registered store data, and a move, insert or append
// copies each byte across the gap through S_MOVE and S_COPY before it finishes.
// An accepted beat is registered in the front-end queue for the back end.
// Reset is synchronous and leaves the store contents undefined; it needs no pass.
// Up to two beats queue in the front end while the back end works; the back end
// starts a command only once the previous result has been popped.
module gap_buffer_editor_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  gbe_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output gbe_pkg::out_item_t out_item
);

  logic          cmd_valid;
  logic          cmd_ready;
  gbe_pkg::cmd_t cmd;

  gbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  gbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

[rtl/gbe_checker.sv]
// Port-level checker for the gap buffer editor and its bind to the top level.
// Depends on gbe_pkg and gap_buffer_editor_top.
module gbe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input gbe_pkg::in_item_t  in_item,
  input logic               empty,
  input logic               pop,
  input gbe_pkg::out_item_t out_item
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before it was popped");

  a_gap_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.gap_start <= out_item.text_count &&
                out_item.text_count <= gbe_pkg::PW'(gbe_pkg::CAPACITY)))
    else $error("gap or length outside the text");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.status == gbe_pkg::ST_OK ||
                out_item.status == gbe_pkg::ST_RANGE ||
                out_item.status == gbe_pkg::ST_FULL))
    else $error("undefined status code");

  a_reject_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != gbe_pkg::ST_OK) |-> (out_item.read_char == 8'd0))
    else $error("rejected command returned a character");

endmodule

bind gap_buffer_editor_top gbe_checker u_checker (.*);
